>>> rtl/core/pcpfl_pkg.sv
`timescale 1ns / 1ps

package pcpfl_pkg;

    localparam int NPAGES     = 32768;
    localparam int CPUS       = 8;
    localparam int PAGE_SHIFT = 12;
    localparam int VA_W       = 40;
    localparam int FIRST_W    = 28;
    localparam int LIMIT_W    = 29;
    localparam int CFG_W      = 29;
    localparam int SLOT_W     = $clog2(NPAGES + 1);
    localparam int LINK_AW    = $clog2(NPAGES);
    localparam int CPU_W      = (CPUS > 1) ? $clog2(CPUS) : 1;

    localparam logic [SLOT_W-1:0]  NULL_SLOT        = SLOT_W'(NPAGES);
    localparam logic [FIRST_W-1:0] FIRST_PAGE_RESET = FIRST_W'(525312);
    localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RESET = LIMIT_W'(557056);

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_INIT   = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADADR = 2'd2,
        ST_RSVD   = 2'd3
    } t_status;

    typedef enum logic {
        REG_FIRST_PAGE = 1'b0,
        REG_PAGE_LIMIT = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_POP,
        S_FREE_CHK,
        S_FREE_PUSH,
        S_INIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic init_start;
        logic scan_step;
        logic scan_read;
        logic pop;
        logic set_empty;
        logic free_chk;
        logic free_push;
        logic set_bad;
        logic init_adv;
        logic init_write;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic head_null;
        logic scan_last;
        logic free_ok;
        logic init_done;
        logic part_end;
    } t_dp_stat;

    function automatic logic [CPU_W-1:0] hart_wrap(input logic [2:0] h);
        logic [3:0] v;
        v = {1'b0, h};
        for (int i = 0; i < 8; i++) begin
            if (v >= 4'(CPUS)) begin
                v = v - 4'(CPUS);
            end
        end
        return CPU_W'(v);
    endfunction

endpackage

>>> rtl/core/pcpfl_ram.sv
`timescale 1ns / 1ps

module pcpfl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/pcpfl_ctrl.sv
`timescale 1ns / 1ps

module pcpfl_ctrl
    import pcpfl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  logic [1:0] i_cmd,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_cmd'(i_cmd))
                        CMD_ALLOC: n_state = S_SCAN;
                        CMD_FREE:  n_state = S_FREE_CHK;
                        CMD_INIT:  n_state = S_INIT;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (!i_stat.head_null) begin
                    n_state = S_POP;
                end else if (i_stat.scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_POP:       n_state = S_DONE;
            S_FREE_CHK:  n_state = S_FREE_PUSH;
            S_FREE_PUSH: n_state = S_DONE;
            S_INIT: begin
                if (i_stat.init_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load       = w_accept;
                o_cmd.init_start = w_accept && (t_cmd'(i_cmd) == CMD_INIT);
            end
            S_SCAN: begin
                o_cmd.scan_read = !i_stat.head_null;
                o_cmd.set_empty = i_stat.head_null && i_stat.scan_last;
                o_cmd.scan_step = i_stat.head_null && !i_stat.scan_last;
            end
            S_POP:      o_cmd.pop = 1'b1;
            S_FREE_CHK: o_cmd.free_chk = 1'b1;
            S_FREE_PUSH: begin
                o_cmd.free_push = i_stat.free_ok;
                o_cmd.set_bad   = !i_stat.free_ok;
            end
            S_INIT: begin
                o_cmd.init_adv   = !i_stat.init_done && i_stat.part_end;
                o_cmd.init_write = !i_stat.init_done && !i_stat.part_end;
            end
            S_DONE:  o_cmd.out_load = w_out_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> rtl/core/pcpfl_dp.sv
`timescale 1ns / 1ps

module pcpfl_dp
    import pcpfl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic [1:0]        i_cmd,
    input  logic [2:0]        i_hart,
    input  logic [VA_W-1:0]   i_addr,
    input  t_dp_cmd           i_dcmd,
    output t_dp_stat          o_stat,
    output logic [VA_W-1:0]   o_page_addr,
    output logic [1:0]        o_status
);

    logic [FIRST_W-1:0] r_first_page;
    logic [LIMIT_W-1:0] r_page_limit;
    logic [SLOT_W-1:0]  r_head [CPUS];
    logic [CPU_W-1:0]   r_idx;
    logic [CPU_W-1:0]   r_k;
    logic [VA_W-1:0]    r_addr;
    logic [SLOT_W-1:0]  r_count;
    logic [SLOT_W-1:0]  r_step;
    logic [SLOT_W-1:0]  r_p;
    logic [SLOT_W-1:0]  r_lo;
    logic [SLOT_W-1:0]  r_hi;
    logic               r_free_ok;
    logic [SLOT_W-1:0]  r_slot;
    logic [VA_W-1:0]    r_res_addr;
    logic [1:0]         r_res_status;
    logic [VA_W-1:0]    r_page_addr;
    logic [1:0]         r_status;

    logic [LIMIT_W-1:0] w_span;
    logic [SLOT_W-1:0]  w_count;
    logic [SLOT_W-1:0]  w_step;
    logic [SLOT_W-1:0]  w_head_cur;
    logic [CPU_W-1:0]   w_idx_inc;
    logic [FIRST_W-1:0] w_page;
    logic [FIRST_W-1:0] w_diff;
    logic               w_free_ok;
    logic [LIMIT_W-1:0] w_sum;
    logic               w_ram_we;
    logic [LINK_AW-1:0] w_ram_waddr;
    logic [SLOT_W-1:0]  w_ram_wdata;
    logic [SLOT_W-1:0]  w_ram_rdata;

    assign w_span  = r_page_limit - {1'b0, r_first_page};
    assign w_count = (r_page_limit <= {1'b0, r_first_page}) ? '0 :
                     (w_span > LIMIT_W'(NPAGES)) ? NULL_SLOT : SLOT_W'(w_span);
    assign w_step  = SLOT_W'(w_count / CPUS);

    assign w_head_cur = r_head[r_idx];
    assign w_idx_inc  = (int'(r_idx) == CPUS - 1) ? '0 : r_idx + 1'b1;

    assign w_page    = r_addr[VA_W-1:PAGE_SHIFT];
    assign w_diff    = w_page - r_first_page;
    assign w_free_ok = (r_addr[PAGE_SHIFT-1:0] == '0) && (w_page >= r_first_page)
                       && (w_diff < FIRST_W'(r_count));

    assign w_sum = {1'b0, r_first_page} + LIMIT_W'(w_head_cur);

    assign o_stat.head_null = (w_head_cur == NULL_SLOT);
    assign o_stat.scan_last = (int'(r_k) == CPUS - 1);
    assign o_stat.free_ok   = r_free_ok;
    assign o_stat.init_done = (r_p == r_count);
    assign o_stat.part_end  = (r_p == r_hi);

    assign w_ram_we    = i_dcmd.free_push || i_dcmd.init_write;
    assign w_ram_waddr = i_dcmd.free_push ? r_slot[LINK_AW-1:0] : r_p[LINK_AW-1:0];
    assign w_ram_wdata = i_dcmd.free_push ? w_head_cur :
                         (r_p == r_lo) ? NULL_SLOT : r_p - 1'b1;

    pcpfl_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (NPAGES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (i_dcmd.scan_read),
        .i_raddr (w_head_cur[LINK_AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_page <= FIRST_PAGE_RESET;
            r_page_limit <= PAGE_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_FIRST_PAGE: r_first_page <= i_cfg_data[FIRST_W-1:0];
                REG_PAGE_LIMIT: r_page_limit <= i_cfg_data[LIMIT_W-1:0];
                default:        r_page_limit <= r_page_limit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CPUS; i++) begin
                r_head[i] <= NULL_SLOT;
            end
        end else if (i_dcmd.init_start) begin
            for (int i = 0; i < CPUS; i++) begin
                r_head[i] <= NULL_SLOT;
            end
        end else if (i_dcmd.pop) begin
            r_head[r_idx] <= w_ram_rdata;
        end else if (i_dcmd.free_push) begin
            r_head[r_idx] <= r_slot;
        end else if (i_dcmd.init_write) begin
            r_head[r_idx] <= r_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dcmd.load) begin
            r_addr       <= i_addr;
            r_count      <= w_count;
            r_k          <= '0;
            r_res_addr   <= '0;
            r_res_status <= ST_OK;
            r_idx        <= (t_cmd'(i_cmd) == CMD_INIT) ? '0 : hart_wrap(i_hart);
        end
        if (i_dcmd.init_start) begin
            r_step <= w_step;
            r_p    <= '0;
            r_lo   <= '0;
            r_hi   <= (CPUS == 1) ? w_count : w_step;
        end
        if (i_dcmd.scan_step) begin
            r_idx <= w_idx_inc;
            r_k   <= r_k + 1'b1;
        end
        if (i_dcmd.pop) begin
            r_res_addr <= VA_W'({w_sum, {PAGE_SHIFT{1'b0}}});
        end
        if (i_dcmd.set_empty) begin
            r_res_status <= ST_EMPTY;
        end
        if (i_dcmd.set_bad) begin
            r_res_status <= ST_BADADR;
        end
        if (i_dcmd.free_chk) begin
            r_free_ok <= w_free_ok;
            r_slot    <= SLOT_W'(w_diff);
        end
        if (i_dcmd.init_adv) begin
            r_idx <= w_idx_inc;
            r_lo  <= r_hi;
            r_hi  <= (int'(r_idx) + 2 == CPUS) ? r_count : r_hi + r_step;
        end
        if (i_dcmd.init_write) begin
            r_p <= r_p + 1'b1;
        end
        if (i_dcmd.out_load) begin
            r_page_addr <= r_res_addr;
            r_status    <= r_res_status;
        end
    end

    assign o_page_addr = r_page_addr;
    assign o_status    = r_status;

endmodule

>>> rtl/core/per_cpu_page_free_list_allocator_top.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake                 | Payload
// in      | input     | i_in_valid / o_in_stall   | i_cmd, i_hart, i_addr
// out     | output    | o_out_valid / i_out_stall | o_page_addr, o_status
// cfg     | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One beat in flight at a time; a new beat is taken while the last result waits.
// Alloc: scans from the hart's list past empty lists; EMPTY if every list is empty.
// Free: checks the address, then pushes onto the hart's list; init: refills all lists.
// Reset clears all lists; link RAM needs no clearing pass.
// A stalled result holds the block in its final state before the next beat.

module per_cpu_page_free_list_allocator_top
    import pcpfl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_cmd,
    input  logic [2:0]        i_hart,
    input  logic [VA_W-1:0]   i_addr,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [VA_W-1:0]   o_page_addr,
    output logic [1:0]        o_status
);

    t_dp_cmd  w_dcmd;
    t_dp_stat w_stat;

    pcpfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_dcmd)
    );

    pcpfl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (i_cmd),
        .i_hart      (i_hart),
        .i_addr      (i_addr),
        .i_dcmd      (w_dcmd),
        .o_stat      (w_stat),
        .o_page_addr (o_page_addr),
        .o_status    (o_status)
    );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pcpfl_pkg::*;

    localparam int QUIET_LIMIT = 120000;

    typedef struct packed {
        t_cmd             cmd;
        logic [2:0]       hart;
        logic [VA_W-1:0]  addr;
        logic             fixed;
        logic [VA_W-1:0]  x_page;
        t_status          x_status;
    } t_page_req;

    typedef struct packed {
        logic [VA_W-1:0]  page;
        t_status          status;
    } t_page_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_cmd;
    logic [2:0]        i_hart;
    logic [VA_W-1:0]   i_addr;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [VA_W-1:0]   o_page_addr;
    logic [1:0]        o_status;

    per_cpu_page_free_list_allocator_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_hart      (i_hart),
        .i_addr      (i_addr),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_page_addr (o_page_addr),
        .o_status    (o_status)
    );

    logic [SLOT_W-1:0]  link_mem [NPAGES];
    logic [SLOT_W-1:0]  head_slot [CPUS];
    logic [FIRST_W-1:0] first_pg;
    logic [LIMIT_W-1:0] limit_pg;

    t_page_result       due_results [$];
    logic [VA_W-1:0]    held_pages [$];
    int                 err_count;
    int                 results_seen;
    int                 burst_left;
    int                 quiet_cycles;

    t_page_req dir_rows [21] = '{
        '{CMD_ALLOC,  3'd0, 40'h00_0000_0000, 1'b1, 40'h00_0000_0000, ST_EMPTY},
        '{CMD_ALLOC,  3'd7, 40'h00_0000_0000, 1'b1, 40'h00_0000_0000, ST_EMPTY},
        '{CMD_UNUSED, 3'd3, 40'hFF_FFFF_FFFF, 1'b1, 40'h00_0000_0000, ST_OK},
        '{CMD_FREE,   3'd0, 40'h00_8040_0001, 1'b1, 40'h00_0000_0000, ST_BADADR},
        '{CMD_FREE,   3'd1, 40'h00_803F_F000, 1'b1, 40'h00_0000_0000, ST_BADADR},
        '{CMD_FREE,   3'd2, 40'h00_8800_0000, 1'b1, 40'h00_0000_0000, ST_BADADR},
        '{CMD_FREE,   3'd6, 40'hFF_FFFF_F000, 1'b1, 40'h00_0000_0000, ST_BADADR},
        '{CMD_FREE,   3'd3, 40'h00_8040_0000, 1'b1, 40'h00_0000_0000, ST_OK},
        '{CMD_FREE,   3'd3, 40'h00_87FF_F000, 1'b1, 40'h00_0000_0000, ST_OK},
        '{CMD_ALLOC,  3'd3, 40'h00_0000_0000, 1'b1, 40'h00_87FF_F000, ST_OK},
        '{CMD_ALLOC,  3'd5, 40'h00_0000_0000, 1'b1, 40'h00_8040_0000, ST_OK},
        '{CMD_ALLOC,  3'd5, 40'h00_0000_0000, 1'b1, 40'h00_0000_0000, ST_EMPTY},
        '{CMD_FREE,   3'd4, 40'h00_8040_0000, 1'b1, 40'h00_0000_0000, ST_OK},
        '{CMD_FREE,   3'd4, 40'h00_8040_0000, 1'b1, 40'h00_0000_0000, ST_OK},
        '{CMD_ALLOC,  3'd4, 40'h00_0000_0000, 1'b0, 40'h00_0000_0000, ST_OK},
        '{CMD_ALLOC,  3'd6, 40'h00_0000_0000, 1'b0, 40'h00_0000_0000, ST_OK},
        '{CMD_INIT,   3'd5, 40'hAA_5555_AAAA, 1'b1, 40'h00_0000_0000, ST_OK},
        '{CMD_ALLOC,  3'd0, 40'h00_0000_0000, 1'b0, 40'h00_0000_0000, ST_OK},
        '{CMD_ALLOC,  3'd7, 40'h00_0000_0000, 1'b0, 40'h00_0000_0000, ST_OK},
        '{CMD_FREE,   3'd2, 40'hFF_FFFF_FFFF, 1'b1, 40'h00_0000_0000, ST_BADADR},
        '{CMD_FREE,   3'd7, 40'h00_87FF_F000, 1'b1, 40'h00_0000_0000, ST_OK}
    };

    function automatic longint unsigned managed_pages();
        longint unsigned n;
        if (limit_pg <= first_pg) return 0;
        n = limit_pg - first_pg;
        if (n > NPAGES) n = NPAGES;
        return n;
    endfunction

    function automatic void apply_page_cmd(input t_cmd c, input logic [2:0] h,
                                           input logic [VA_W-1:0] a,
                                           output logic [VA_W-1:0] pa,
                                           output t_status st);
        longint unsigned cnt, pg, lo, hi, part_len, base;
        int                k, cpu, hh;
        logic [SLOT_W-1:0] s;
        bit                got;
        cnt = managed_pages();
        pa  = '0;
        st  = ST_OK;
        got = 1'b0;
        s   = '0;
        hh  = int'(h) % CPUS;
        case (c)
            CMD_ALLOC: begin
                for (k = 0; k < CPUS && !got; k++) begin
                    cpu = (hh + k) % CPUS;
                    if (head_slot[cpu] != NULL_SLOT) begin
                        s = head_slot[cpu];
                        head_slot[cpu] = link_mem[s];
                        got = 1'b1;
                    end
                end
                if (got) begin
                    base = first_pg;
                    base = base + s;
                    pa = VA_W'(base << PAGE_SHIFT);
                end else begin
                    st = ST_EMPTY;
                end
            end
            CMD_FREE: begin
                pg = a >> PAGE_SHIFT;
                if (a[PAGE_SHIFT-1:0] != '0 || pg < first_pg || pg - first_pg >= cnt) begin
                    st = ST_BADADR;
                end else begin
                    s = SLOT_W'(pg - first_pg);
                    link_mem[s] = head_slot[hh];
                    head_slot[hh] = s;
                end
            end
            CMD_INIT: begin
                part_len = cnt / CPUS;
                for (cpu = 0; cpu < CPUS; cpu++) begin
                    lo = cpu * part_len;
                    hi = (cpu == CPUS - 1) ? cnt : lo + part_len;
                    head_slot[cpu] = NULL_SLOT;
                    for (pg = lo; pg < hi; pg++) begin
                        link_mem[pg] = head_slot[cpu];
                        head_slot[cpu] = SLOT_W'(pg);
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_page_req random_req(input int init_pct);
        t_page_req       r;
        int unsigned     roll, k;
        longint unsigned cnt, pg;
        cnt = managed_pages();
        r = '0;
        r.hart = 3'($urandom);
        r.addr = VA_W'({$urandom, $urandom});
        roll = $urandom_range(0, 99);
        if (roll < init_pct) r.cmd = CMD_INIT;
        else if (roll < init_pct + 3) r.cmd = CMD_UNUSED;
        else if (roll < 55) r.cmd = CMD_ALLOC;
        else r.cmd = CMD_FREE;
        if (r.cmd == CMD_FREE) begin
            roll = $urandom_range(0, 9);
            if (roll < 6 && held_pages.size() > 0) begin
                k = $urandom_range(0, held_pages.size() - 1);
                r.addr = held_pages[k];
                held_pages.delete(k);
            end else if (roll < 9) begin
                pg = first_pg;
                pg = pg + $urandom_range(0, int'(cnt) + 1);
                r.addr = VA_W'(pg << PAGE_SHIFT);
            end else if ($urandom_range(0, 1) == 1) begin
                pg = first_pg;
                r.addr = VA_W'((pg - 1) << PAGE_SHIFT);
            end
        end
        return r;
    endfunction

    task automatic report(input string msg);
        err_count++;
        if (err_count <= 40) $display("%0t ns: %s", $time, msg);
    endtask

    task automatic set_range(input logic [CFG_W-1:0] fp, input logic [CFG_W-1:0] lim);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_FIRST_PAGE;
        i_cfg_data  <= fp;
        @(posedge i_clk);
        i_cfg_index <= REG_PAGE_LIMIT;
        i_cfg_data  <= lim;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        first_pg = fp[FIRST_W-1:0];
        limit_pg = lim[LIMIT_W-1:0];
    endtask

    task automatic offer(input t_page_req r);
        t_page_result res;
        logic [VA_W-1:0] pa;
        t_status st;
        i_in_valid <= 1'b1;
        i_cmd      <= r.cmd;
        i_hart     <= r.hart;
        i_addr     <= r.addr;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        apply_page_cmd(r.cmd, r.hart, r.addr, pa, st);
        if (r.cmd == CMD_INIT) held_pages.delete();
        if (r.cmd == CMD_ALLOC && st == ST_OK) held_pages.push_back(pa);
        res.page   = r.fixed ? r.x_page : pa;
        res.status = r.fixed ? r.x_status : st;
        due_results.push_back(res);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic drain();
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_page_result e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (due_results.size() == 0) begin
                report($sformatf("unexpected beat: page %h status %0d", o_page_addr, o_status));
            end else begin
                e = due_results.pop_front();
                if (o_page_addr !== e.page)
                    report($sformatf("page_addr %h, want %h", o_page_addr, e.page));
                if (o_status !== e.status)
                    report($sformatf("status %0d, want %0d", o_status, e.status));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int  len, mode;
        bit  pressure_done;
        pressure_done = 1'b0;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!pressure_done && results_seen >= 40) begin
                pressure_done = 1'b1;
                repeat (400) begin
                    @(posedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end else if ($urandom_range(0, 59) == 0) begin
                repeat ($urandom_range(100, 250)) begin
                    @(posedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end else begin
                len  = $urandom_range(5, 60);
                mode = $urandom_range(0, 3);
                repeat (len) begin
                    @(posedge i_clk);
                    case (mode)
                        0: i_out_stall <= 1'b0;
                        1: i_out_stall <= ($urandom_range(0, 3) == 0);
                        2: i_out_stall <= ($urandom_range(0, 3) != 0);
                        default: i_out_stall <= ~i_out_stall;
                    endcase
                end
            end
        end
    end

    initial begin
        int                ph, n, pct, i;
        bit                do_init;
        logic [CFG_W-1:0]  fp, lim;
        t_page_req         r;

        err_count    = 0;
        results_seen = 0;
        burst_left   = 0;
        quiet_cycles = 0;
        first_pg     = FIRST_PAGE_RESET;
        limit_pg     = PAGE_LIMIT_RESET;
        for (i = 0; i < CPUS; i++) head_slot[i] = NULL_SLOT;

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= REG_FIRST_PAGE;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_cmd       <= CMD_ALLOC;
        i_hart      <= '0;
        i_addr      <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) offer(dir_rows[k]);

        for (ph = 0; ph < 9; ph++) begin
            case (ph)
                0: begin fp = 1000; lim = 1040; n = 120; do_init = 1; pct = 4; end
                1: begin fp = 1000; lim = 1003; n = 60; do_init = 0; pct = 5; end
                2: begin
                    fp = CFG_W'($urandom_range(0, 268435400));
                    lim = fp + $urandom_range(8, 48);
                    n = 100; do_init = 1; pct = 4;
                end
                3: begin fp = 268435455; lim = 268435456; n = 60; do_init = 0; pct = 5; end
                4: begin fp = 268435455; lim = 0; n = 50; do_init = 1; pct = 5; end
                5: begin fp = 0; lim = 0; n = 40; do_init = 0; pct = 5; end
                6: begin fp = 0; lim = 268435456; n = 40; do_init = 1; pct = 0; end
                7: begin fp = 0; lim = 64; n = 120; do_init = 1; pct = 6; end
                default: begin
                    fp = CFG_W'($urandom_range(0, 268435455));
                    lim = fp + $urandom_range(0, 40);
                    n = 150; do_init = $urandom_range(0, 1); pct = 4;
                end
            endcase
            // hold input low and let the block settle before touching registers
            i_in_valid <= 1'b0;
            drain();
            repeat (4) @(posedge i_clk);
            set_range(fp, lim);
            held_pages.delete();
            if (do_init) begin
                r = '0;
                r.cmd  = CMD_INIT;
                r.hart = 3'($urandom);
                offer(r);
            end
            repeat (n) offer(random_req(pct));
        end

        i_in_valid <= 1'b0;
        drain();
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
